### hw/rtl/csa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants of the contiguous slot allocator
// Request and response payloads, request modes and memory control.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int NUM_SLOTS_DEF = 64;
    localparam int CFG_W         = 7;
    localparam int START_W       = 6;
    localparam int LEN_W         = 7;

    localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;

    localparam logic [1:0] MODE_LEFT   = 2'd0;
    localparam logic [1:0] MODE_RIGHT  = 2'd1;
    localparam logic [1:0] MODE_OCCUPY = 2'd2;
    localparam logic [1:0] MODE_FREE   = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [START_W-1:0] start_slot;
        logic [LEN_W-1:0]   run_length;
    } csa_req_t;

    typedef struct packed {
        logic               success;
        logic [START_W-1:0] found_start;
    } csa_rsp_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_bit;
    } csa_mem_ctl_t;

endpackage

### hw/rtl/csa_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_bitmap: slot occupancy memory
// Single-port bit memory, one read or write a cycle, registered read data.
// ----------------------------------------------------------------------------
module csa_bitmap #(
    parameter int NUM_SLOTS = csa_pkg::NUM_SLOTS_DEF
) (
    input  logic                         clk,
    input  csa_pkg::csa_mem_ctl_t        mem_ctl,
    input  logic [$clog2(NUM_SLOTS)-1:0] mem_addr,
    output logic                         mem_rd_bit
);
    import csa_pkg::*;

    logic busy_mem [NUM_SLOTS];
    logic rd_bit_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            busy_mem[mem_addr] <= mem_ctl.wr_bit;
        end
        if (mem_ctl.rd_en)
        begin
            rd_bit_reg <= busy_mem[mem_addr];
        end
    end

    assign mem_rd_bit = rd_bit_reg;

endmodule

### hw/rtl/csa_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_seq: request sequencer of the contiguous slot allocator
// Walks the bitmap one slot a cycle for clears, range writes and run searches.
// ----------------------------------------------------------------------------
module csa_seq #(
    parameter int NUM_SLOTS = csa_pkg::NUM_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [csa_pkg::CFG_W-1:0]    slots,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  csa_pkg::csa_req_t            in_data,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output csa_pkg::csa_rsp_t            rsp_data,
    output csa_pkg::csa_mem_ctl_t        mem_ctl,
    output logic [$clog2(NUM_SLOTS)-1:0] mem_addr,
    input  logic                         mem_rd_bit
);
    import csa_pkg::*;

    localparam int ADDR_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [LEN_W-1:0]   run_reg, run_next;
    logic               chk_vld_reg, chk_vld_next;
    logic               chk_last_reg, chk_last_next;
    logic [ADDR_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [1:0]         mode_reg, mode_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               wbit_reg, wbit_next;
    logic               ok_reg, ok_next;
    logic [START_W-1:0] where_reg, where_next;

    logic [CMP_W-1:0] slots_ext;
    logic [CMP_W-1:0] n_w;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] start_ext;
    logic [CMP_W-1:0] end_ext;
    logic [CMP_W-1:0] left_start;
    logic [LEN_W-1:0] run_upd;

    assign slots_ext  = CMP_W'(slots);
    assign n_w        = (slots_ext > CMP_W'(NUM_SLOTS)) ? CMP_W'(NUM_SLOTS) : slots_ext;
    assign len_ext    = CMP_W'(in_data.run_length);
    assign start_ext  = CMP_W'(in_data.start_slot);
    assign end_ext    = start_ext + len_ext;
    assign left_start = CMP_W'(chk_idx_reg) + CMP_W'(1) - CMP_W'(len_reg);
    assign run_upd    = mem_rd_bit ? '0 : run_reg + LEN_W'(1);

    assign in_ready  = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_RESP);
    assign rsp_data  = '{success: ok_reg, found_start: where_reg};
    assign mem_addr  = addr_reg;

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        left_next     = left_reg;
        run_next      = run_reg;
        chk_vld_next  = 1'b0;
        chk_last_next = 1'b0;
        chk_idx_next  = chk_idx_reg;
        mode_next     = mode_reg;
        len_next      = len_reg;
        wbit_next     = wbit_reg;
        ok_next       = ok_reg;
        where_next    = where_reg;
        mem_ctl       = '{rd_en: 1'b0, wr_en: 1'b0, wr_bit: 1'b0};

        case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl   = '{rd_en: 1'b0, wr_en: 1'b1, wr_bit: 1'b0};
                addr_next = addr_reg + ADDR_W'(1);
                left_next = left_reg - CNT_W'(1);
                if (left_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = in_data.mode;
                    len_next   = in_data.run_length;
                    wbit_next  = (in_data.mode == MODE_OCCUPY);
                    run_next   = '0;
                    ok_next    = 1'b0;
                    where_next = '0;
                    state_next = ST_RESP;
                    if (in_data.mode == MODE_LEFT || in_data.mode == MODE_RIGHT)
                    begin
                        if (in_data.run_length != '0 && len_ext <= n_w)
                        begin
                            state_next = ST_SCAN;
                            left_next  = n_w[CNT_W-1:0];
                            if (in_data.mode == MODE_LEFT)
                            begin
                                addr_next = '0;
                            end
                            else
                            begin
                                addr_next = ADDR_W'(n_w - CMP_W'(1));
                            end
                        end
                    end
                    else if (in_data.run_length != '0 && start_ext < n_w && end_ext <= n_w)
                    begin
                        state_next = ST_WRITE;
                        addr_next  = start_ext[ADDR_W-1:0];
                        left_next  = len_ext[CNT_W-1:0];
                        ok_next    = 1'b1;
                        where_next = in_data.start_slot;
                    end
                end
            end
            ST_SCAN:
            begin
                if (left_reg != '0)
                begin
                    mem_ctl       = '{rd_en: 1'b1, wr_en: 1'b0, wr_bit: 1'b0};
                    chk_vld_next  = 1'b1;
                    chk_last_next = (left_reg == CNT_W'(1));
                    chk_idx_next  = addr_reg;
                    left_next     = left_reg - CNT_W'(1);
                    if (mode_reg == MODE_LEFT)
                    begin
                        addr_next = addr_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        addr_next = addr_reg - ADDR_W'(1);
                    end
                end
                if (chk_vld_reg)
                begin
                    run_next = run_upd;
                    if (run_upd >= len_reg)
                    begin
                        state_next = ST_RESP;
                        ok_next    = 1'b1;
                        if (mode_reg == MODE_LEFT)
                        begin
                            where_next = left_start[START_W-1:0];
                        end
                        else
                        begin
                            where_next = START_W'(CMP_W'(chk_idx_reg));
                        end
                    end
                    else if (chk_last_reg)
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_WRITE:
            begin
                mem_ctl   = '{rd_en: 1'b0, wr_en: 1'b1, wr_bit: wbit_reg};
                addr_next = addr_reg + ADDR_W'(1);
                left_next = left_reg - CNT_W'(1);
                if (left_reg == CNT_W'(1))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            left_reg     <= CNT_W'(NUM_SLOTS);
            chk_vld_reg  <= 1'b0;
            chk_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            left_reg     <= left_next;
            chk_vld_reg  <= chk_vld_next;
            chk_last_reg <= chk_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg     <= run_next;
        chk_idx_reg <= chk_idx_next;
        mode_reg    <= mode_next;
        len_reg     <= len_next;
        wbit_reg    <= wbit_next;
        ok_reg      <= ok_next;
        where_reg   <= where_next;
    end

endmodule

### hw/rtl/contiguous_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_slot_allocator: first-fit allocator over a slot occupancy bitmap
// Searches for free runs from either end, and occupies or frees slot ranges.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready as csa_req_t, one at a time.
//   Each request yields one csa_rsp_t on out_valid/out_ready.
//   cfg_valid/cfg_ready writes slots_reg; write it only while idle.
//   A search walks the bitmap memory one slot a cycle from the chosen end
//   and stops at the first fitting run. Occupy and free write one slot a
//   cycle; rejected requests skip the bitmap and answer directly.
//   The single bitmap port sets the pace; in_ready is low while a request
//   is at work or its response waits in the sequencer.
//   After reset the bitmap is cleared one slot a cycle, with in_ready low;
//   cfg writes are taken during the clear.
//   A stalled receiver holds the response in the output register; one more
//   request may be accepted and worked meanwhile.
// ----------------------------------------------------------------------------
module contiguous_slot_allocator #(
    parameter int NUM_SLOTS = csa_pkg::NUM_SLOTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  csa_pkg::csa_req_t         in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output csa_pkg::csa_rsp_t         out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [csa_pkg::CFG_W-1:0] cfg_data
);
    import csa_pkg::*;

    localparam int ADDR_W = $clog2(NUM_SLOTS);

    logic [CFG_W-1:0]  slots_reg;
    logic              out_valid_reg;
    csa_rsp_t          out_data_reg;
    logic              rsp_valid;
    logic              rsp_ready;
    csa_rsp_t          rsp_data;
    csa_mem_ctl_t      mem_ctl;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_rd_bit;

    assign cfg_ready = 1'b1;
    assign rsp_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    csa_seq #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .slots     (slots_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_rd_bit(mem_rd_bit)
    );

    csa_bitmap #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_bitmap (
        .clk       (clk),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_rd_bit(mem_rd_bit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg     <= SLOTS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                slots_reg <= cfg_data;
            end
            if (rsp_valid && rsp_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            out_data_reg <= rsp_data;
        end
    end

endmodule

### hw/rtl/csa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_checker: port-level checks of the contiguous slot allocator
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module csa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input csa_pkg::csa_rsp_t out_data
);
    import csa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response dropped before transfer");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is at work");

    a_ready_falls_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("in_ready dropped without a request transfer");

    a_fail_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.success |-> out_data.found_start == '0)
        else $error("failed response carries a nonzero start");

endmodule

bind contiguous_slot_allocator csa_checker u_csa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the contiguous slot allocator
// Drives search, occupy and free requests over valid/ready with random gaps
// and receiver stalls, keeps a bit-accurate copy of the occupancy bitmap and
// the managed slot count, and checks every response in order against it.
// The slot count is rewritten between phases, its extremes included.
// ----------------------------------------------------------------------------
module tb;

    import csa_pkg::*;

    localparam int SLOT_TOTAL  = NUM_SLOTS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 80;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    csa_req_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    csa_rsp_t             out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic [SLOT_TOTAL-1:0] slot_map = '0;
    logic [CFG_W-1:0]      slot_count = SLOTS_RESET;
    csa_rsp_t              awaited_rsp[$];
    int                    error_count = 0;
    int                    idle_cycles = 0;
    int                    stall_left = 0;
    bit                    quiet_tail = 1'b0;

    contiguous_slot_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int managed_count();
        return (slot_count > SLOT_TOTAL) ? SLOT_TOTAL : int'(slot_count);
    endfunction

    function automatic csa_rsp_t allocate(input csa_req_t req);
        int       managed;
        int       len;
        int       first;
        int       run;
        int       where;
        bit       ok;
        csa_rsp_t rsp;
        managed = managed_count();
        len     = req.run_length;
        first   = req.start_slot;
        run     = 0;
        where   = 0;
        ok      = 1'b0;
        if (len != 0)
        begin
            case (req.mode)
                MODE_LEFT:
                    for (int i = 0; i < managed && !ok; i++)
                    begin
                        run = slot_map[i] ? 0 : run + 1;
                        if (run >= len)
                        begin
                            ok    = 1'b1;
                            where = i + 1 - len;
                        end
                    end
                MODE_RIGHT:
                    for (int i = managed - 1; i >= 0 && !ok; i--)
                    begin
                        run = slot_map[i] ? 0 : run + 1;
                        if (run >= len)
                        begin
                            ok    = 1'b1;
                            where = i;
                        end
                    end
                default:
                    if (first < managed && first + len <= managed)
                    begin
                        for (int i = first; i < first + len; i++)
                            slot_map[i] = (req.mode == MODE_OCCUPY);
                        ok    = 1'b1;
                        where = first;
                    end
            endcase
        end
        rsp.success     = ok;
        rsp.found_start = ok ? where[START_W-1:0] : '0;
        return rsp;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        csa_rsp_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_rsp.size() == 0)
                    report_mismatch($sformatf("response %p with none outstanding", out_data));
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (out_data.success !== want.success)
                        report_mismatch($sformatf("success got %b want %b",
                                                  out_data.success, want.success));
                    if (out_data.found_start !== want.found_start)
                        report_mismatch($sformatf("found_start got %0d want %0d",
                                                  out_data.found_start, want.found_start));
                end
            end
            if (cfg_valid && cfg_ready)
                slot_count = cfg_data;
            if (in_valid && in_ready)
                awaited_rsp.push_back(allocate(in_data));
        end
    end

    always @(negedge clk)
    begin
        if (quiet_tail)
            out_ready = 1'b1;
        else if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            out_ready  = 1'b0;
            stall_left = $urandom_range(0, 11);
        end
        else
            out_ready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] mode, input int first, input int len);
        @(negedge clk);
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid           = 1'b1;
        in_data.mode       = mode;
        in_data.start_slot = first[START_W-1:0];
        in_data.run_length = len[LEN_W-1:0];
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_slot_count(input logic [CFG_W-1:0] value);
        wait_for_drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_search_extremes();
        write_slot_count(7'd64);
        send_request(MODE_LEFT, 0, 1);
        send_request(MODE_RIGHT, 63, 1);
        send_request(MODE_LEFT, 63, 64);
        send_request(MODE_RIGHT, 0, 64);
        send_request(MODE_LEFT, 0, 65);
        send_request(MODE_RIGHT, 0, 127);
        send_request(MODE_LEFT, 0, 0);
        send_request(MODE_RIGHT, 0, 0);
        send_request(MODE_OCCUPY, 0, 0);
    endtask

    task automatic test_occupy_free();
        send_request(MODE_OCCUPY, 0, 1);
        send_request(MODE_OCCUPY, 63, 1);
        send_request(MODE_LEFT, 0, 62);
        send_request(MODE_RIGHT, 0, 62);
        send_request(MODE_LEFT, 0, 63);
        send_request(MODE_OCCUPY, 63, 2);
        send_request(MODE_FREE, 0, 64);
        send_request(MODE_OCCUPY, 20, 10);
        send_request(MODE_RIGHT, 0, 34);
        send_request(MODE_FREE, 42, 0);
        send_request(MODE_FREE, 42, 127);
    endtask

    task automatic test_slot_count_extremes();
        write_slot_count(7'd0);
        send_request(MODE_LEFT, 0, 1);
        send_request(MODE_FREE, 0, 1);
        write_slot_count(7'd127);
        send_request(MODE_RIGHT, 0, 1);
        write_slot_count(7'd1);
        send_request(MODE_OCCUPY, 0, 1);
        send_request(MODE_LEFT, 0, 1);
        send_request(MODE_FREE, 0, 1);
        send_request(MODE_OCCUPY, 1, 1);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] setting;
        logic [1:0]       mode;
        int               managed;
        int               len;
        int               first;
        int               count;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:       setting = 7'd64;
                1:       setting = 7'($urandom_range(2, 16));
                2:       setting = 7'd127;
                3:       setting = 7'($urandom_range(65, 127));
                4:       setting = 7'd1;
                5:       setting = 7'($urandom_range(17, 63));
                6:       setting = 7'd0;
                7:       setting = 7'd63;
                8:       setting = 7'($urandom_range(1, 64));
                default: setting = 7'd64;
            endcase
            write_slot_count(setting);
            if (phase == 9)
                quiet_tail = 1'b1;
            count = (phase == 6) ? 10 : 55;
            for (int k = 0; k < count; k++)
            begin
                managed = managed_count();
                mode    = 2'($urandom_range(0, 3));
                if (managed > 0 && $urandom_range(0, 9) < 8)
                begin
                    if ($urandom_range(0, 7) == 0)
                        len = $urandom_range(1, managed);
                    else
                        len = $urandom_range(1, (managed < 12) ? managed : 12);
                    first = $urandom_range(0, managed - len);
                end
                else
                begin
                    len   = $urandom_range(0, 127);
                    first = $urandom_range(0, 63);
                end
                send_request(mode, first, len);
                if (phase == 1 && k == count / 2)
                    wait_for_drain();
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_search_extremes();
        test_occupy_free();
        test_slot_count_extremes();
        test_random_traffic();
        wait_for_drain();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
